FILE: rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

    localparam int TICKS_PER_CM = 36;
    localparam int SENSOR_COUNT = 3;

    localparam int DIST_W  = 11;
    localparam int COUNT_W = 17;
    localparam int ECHO_W  = 16;

    localparam logic [DIST_W-1:0]  FAIL_DISTANCE = 11'd999;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE  = 11'd2047;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT   = 17'h10000;

    // reciprocal for count / TICKS_PER_CM, exact for any 16-bit count
    localparam int DIV_SHIFT = ECHO_W + $clog2(TICKS_PER_CM);
    localparam int RECIP_W   = ECHO_W + 2;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));
    localparam int PROD_W = ECHO_W + RECIP_W;

    localparam logic [1:0] REG_TRIGGER_LENGTH  = 2'd0;
    localparam logic [1:0] REG_ECHO_WAIT_LIMIT = 2'd1;
    localparam logic [1:0] REG_HOLDOFF_LENGTH  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ECHO    = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_BAD_SENSOR = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  trigger_length;
        logic [15:0] echo_wait_limit;
        logic [15:0] holdoff_length;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        logic [1:0] sensor_select;
        logic [2:0] echo_levels;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        status_t           status;
        logic              done_res;
        logic              busy_res;
        logic [2:0]        trigger_lines;
    } result_t;

endpackage

FILE: rtl/uer_regs.sv
// APB configuration registers of the echo ranger.
// Depends on uer_pkg for the register map and the cfg_t group.
module uer_regs
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_length  <= 8'd7;
            cfg_reg.echo_wait_limit <= 16'd3125;
            cfg_reg.holdoff_length  <= 16'd25000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TRIGGER_LENGTH:  cfg_reg.trigger_length  <= pwdata[7:0];
                REG_ECHO_WAIT_LIMIT: cfg_reg.echo_wait_limit <= pwdata[15:0];
                REG_HOLDOFF_LENGTH:  cfg_reg.holdoff_length  <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TRIGGER_LENGTH:  prdata = {24'd0, cfg_reg.trigger_length};
            REG_ECHO_WAIT_LIMIT: prdata = {16'd0, cfg_reg.echo_wait_limit};
            REG_HOLDOFF_LENGTH:  prdata = {16'd0, cfg_reg.holdoff_length};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/uer_seq.sv
// Measurement sequencer: phase, tick counter and selected sensor, plus the
// per-tick result logic. Depends on uer_pkg.
module uer_seq
    import uer_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TRIGGER = 3'd1,
        PH_WAIT    = 3'd2,
        PH_MEASURE = 3'd3,
        PH_HOLDOFF = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         sensor_reg, sensor_next;

    phase_t             cur_phase;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         trig_len;
    logic [3:0]         echo_shift;
    logic               echo;
    logic [PROD_W-1:0]  product;
    logic [ECHO_W-1:0]  quotient;
    logic [DIST_W-1:0]  dist_sat;

    assign trig_len = (cfg.trigger_length == 8'd0) ? 8'd1 : cfg.trigger_length;

    // count / TICKS_PER_CM by reciprocal multiply
    assign product  = PROD_W'(count_reg[ECHO_W-1:0]) * PROD_W'(DIV_RECIP);
    assign quotient = ECHO_W'(product >> DIV_SHIFT);
    assign dist_sat = (quotient > ECHO_W'(MAX_DISTANCE)) ? MAX_DISTANCE
                                                         : quotient[DIST_W-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sensor_next = sensor_reg;
        res         = '0;
        res.status  = ST_OK;
        res.busy_res = (phase_reg != PH_IDLE);

        cur_phase = phase_reg;
        cur_count = count_reg;

        if (phase_reg == PH_IDLE && item.cmd)
        begin
            if (32'(item.sensor_select) >= SENSOR_COUNT)
            begin
                res.done_res    = 1'b1;
                res.status      = ST_BAD_SENSOR;
                res.distance_cm = FAIL_DISTANCE;
            end
            else
            begin
                res.busy_res = 1'b1;
                sensor_next  = item.sensor_select;
                cur_phase    = PH_TRIGGER;
                cur_count    = '0;
            end
        end

        echo_shift = {1'b0, item.echo_levels} >> sensor_next;
        echo       = echo_shift[0];
        count_inc  = cur_count + 1'b1;
        phase_next = cur_phase;
        count_next = cur_count;

        unique case (cur_phase)
            PH_IDLE: ;
            PH_TRIGGER:
            begin
                res.trigger_lines = 3'(4'b0001 << sensor_next);
                if (count_inc >= COUNT_W'(trig_len))
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    phase_next = PH_MEASURE;
                    count_next = COUNT_W'(1);
                end
                else if (count_inc >= COUNT_W'(cfg.echo_wait_limit))
                begin
                    res.done_res    = 1'b1;
                    res.status      = ST_NO_ECHO;
                    res.distance_cm = FAIL_DISTANCE;
                    phase_next      = PH_IDLE;
                    count_next      = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_MEASURE:
            begin
                if (echo && count_inc < COUNT_LIMIT)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    res.done_res    = 1'b1;
                    res.status      = echo ? ST_OVERFLOW : ST_OK;
                    res.distance_cm = echo ? FAIL_DISTANCE : dist_sat;
                    count_next      = '0;
                    phase_next      = (cfg.holdoff_length != 16'd0) ? PH_HOLDOFF : PH_IDLE;
                end
            end
            PH_HOLDOFF:
            begin
                if (count_inc >= COUNT_W'(cfg.holdoff_length))
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            sensor_reg <= 2'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sensor_reg <= sensor_next;
        end
    end

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: input beat register, sequencer, result
// register and APB registers. Depends on uer_pkg, uer_regs, uer_seq.
//
//  port group   dir  carries
//  s_*          in   one timer tick per beat: start request, sensor, echo levels
//  m_*          out  one result per tick: triggers, busy, done, status, distance
//  p*           in   APB writes/reads of trigger, echo wait and holdoff lengths
//
// One tick per clock unless the m side stalls; beat and result are each registered.
// The tick path is input register -> phase logic and divide-by-36 multiply
// -> result register. rst_n clears phase, counter, sensor and valid flags.
// A stalled m side backs up into s_tready only when both registers are full.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] sensor_select, [4:2] echo_levels
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] trigger_lines, [3] busy_res, [4] done_res,
                                   // [6:5] status, [17:7] distance_cm
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg};

    uer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd           <= s_tuser;
            in_item_reg.sensor_select <= s_tdata[1:0];
            in_item_reg.echo_levels   <= s_tdata[4:2];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

`ifndef SYNTH
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.done_res |->
            out_res_reg.status == ST_OK && out_res_reg.distance_cm == '0)
        else $error("status or distance set without done");

    a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(out_res_reg.trigger_lines))
        else $error("more than one trigger line driven");

    a_fail_distance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.done_res && out_res_reg.status != ST_OK |->
            out_res_reg.distance_cm == FAIL_DISTANCE)
        else $error("failure result without fail distance");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while a register is free");
`endif

endmodule
